[sv/obrb_pkg.sv]
// Package: shared types and constants for the overwriting byte ring buffer.
package obrb_pkg;

    localparam int DEF_DEPTH = 256;
    localparam int DATA_W    = 8;
    localparam int IDX_W     = 8;
    localparam int CAP_W     = 9;
    localparam int CNT_W     = 9;
    localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

    typedef enum logic [1:0] {
        OP_PUT   = 2'd0,
        OP_GET   = 2'd1,
        OP_PEEK  = 2'd2,
        OP_RESET = 2'd3
    } t_op;

    // controller -> datapath commands
    typedef struct packed {
        logic load_item;   // capture the accepted transfer
        logic exec;        // run the operation on pointers and store
        logic load_out;    // capture the result into the output register
    } t_cmd;

endpackage

[sv/obrb_if.sv]
// Interfaces: input and result channels with valid/ready handshake.
interface obrb_in_if;
    logic                            valid;
    logic                            ready;
    logic [1:0]                      operation;
    logic [obrb_pkg::DATA_W-1:0]     data_in;
    logic [obrb_pkg::IDX_W-1:0]      peek_index;

    modport source (output valid, operation, data_in, peek_index, input ready);
    modport sink   (input valid, operation, data_in, peek_index, output ready);
endinterface

interface obrb_out_if;
    logic                            valid;
    logic                            ready;
    logic                            ok;
    logic [obrb_pkg::DATA_W-1:0]     data_out;
    logic [obrb_pkg::CNT_W-1:0]      count;
    logic                            is_full;
    logic                            is_empty;

    modport source (output valid, ok, data_out, count, is_full, is_empty, input ready);
    modport sink   (input valid, ok, data_out, count, is_full, is_empty, output ready);
endinterface

[sv/obrb_ctrl.sv]
// Controller: sequences accept, execute and result load; owns the handshakes.
module obrb_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output obrb_pkg::t_cmd  o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   slot_free;

    assign slot_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        o_in_ready  = 1'b0;
        o_cmd       = '0;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_item = 1'b1;
                    n_state         = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = S_DONE;
            end
            S_DONE: begin
                if (slot_free) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

[sv/obrb_dp.sv]
// Datapath: byte store, ring pointers, count logic and result register.
module obrb_dp #(
    parameter int DEPTH = obrb_pkg::DEF_DEPTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  obrb_pkg::t_cmd                  i_cmd,
    input  logic                            i_cfg_we,
    input  logic [obrb_pkg::CAP_W-1:0]      i_cfg_data,
    input  logic [1:0]                      i_operation,
    input  logic [obrb_pkg::DATA_W-1:0]     i_data_in,
    input  logic [obrb_pkg::IDX_W-1:0]      i_peek_index,
    output logic                            o_ok,
    output logic [obrb_pkg::DATA_W-1:0]     o_data_out,
    output logic [obrb_pkg::CNT_W-1:0]      o_count,
    output logic                            o_is_full,
    output logic                            o_is_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    // wide enough for DEPTH itself, the capacity register and rp + peek_index
    localparam int W  = (AW + 1 > obrb_pkg::CAP_W) ? AW + 1 : obrb_pkg::CAP_W;
    localparam logic [W-1:0] DEPTH_W = W'(DEPTH);

    // item captured at accept
    obrb_pkg::t_op                  r_op;
    logic [obrb_pkg::DATA_W-1:0]    r_din;
    logic [obrb_pkg::IDX_W-1:0]     r_pidx;

    // ring state
    logic [W-1:0]                   r_cap;
    logic [AW-1:0]                  r_wp, r_rp;
    logic                           r_full;

    // store
    logic [obrb_pkg::DATA_W-1:0]    r_mem [DEPTH];
    logic [obrb_pkg::DATA_W-1:0]    r_mem_q;

    // execute results
    logic                           r_xok, r_xrd;

    // output register
    logic                           r_ok, r_full_o, r_empty_o;
    logic [obrb_pkg::DATA_W-1:0]    r_dout;
    logic [obrb_pkg::CNT_W-1:0]     r_count;

    logic [W-1:0]   cap_in, wp_w, rp_w, cnt, wp_inc, rp_inc, pos_sum, pos;
    logic [AW-1:0]  wp_adv, rp_adv, rd_addr;
    logic           cnt_zero, peek_ok;

    // capacity zero acts as one, anything above DEPTH saturates
    always_comb begin
        cap_in = W'(i_cfg_data);
        if (cap_in == '0) begin
            cap_in = W'(1);
        end
        if (cap_in > DEPTH_W) begin
            cap_in = DEPTH_W;
        end
    end

    assign wp_w   = W'(r_wp);
    assign rp_w   = W'(r_rp);
    assign wp_inc = wp_w + W'(1);
    assign rp_inc = rp_w + W'(1);
    assign wp_adv = (wp_inc >= r_cap) ? '0 : wp_inc[AW-1:0];
    assign rp_adv = (rp_inc >= r_cap) ? '0 : rp_inc[AW-1:0];

    always_comb begin
        if (r_full) begin
            cnt = r_cap;
        end else if (wp_w >= rp_w) begin
            cnt = wp_w - rp_w;
        end else begin
            cnt = r_cap + wp_w - rp_w;
        end
    end

    assign cnt_zero = (cnt == '0);
    assign peek_ok  = (W'(r_pidx) < cnt);
    assign pos_sum  = rp_w + W'(r_pidx);
    assign pos      = (pos_sum >= r_cap) ? pos_sum - r_cap : pos_sum;
    assign rd_addr  = (r_op == obrb_pkg::OP_PEEK) ? pos[AW-1:0] : r_rp;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_op   <= obrb_pkg::t_op'(i_operation);
            r_din  <= i_data_in;
            r_pidx <= i_peek_index;
        end
    end

    // store write and registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            if (r_op == obrb_pkg::OP_PUT) begin
                r_mem[r_wp] <= r_din;
            end
            r_mem_q <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap  <= W'(obrb_pkg::CAP_RESET) > DEPTH_W ? DEPTH_W : W'(obrb_pkg::CAP_RESET);
            r_wp   <= '0;
            r_rp   <= '0;
            r_full <= 1'b0;
        end else if (i_cfg_we) begin
            r_cap  <= cap_in;
            r_wp   <= '0;
            r_rp   <= '0;
            r_full <= 1'b0;
        end else if (i_cmd.exec) begin
            case (r_op)
                obrb_pkg::OP_PUT: begin
                    r_wp   <= wp_adv;
                    if (r_full) begin
                        r_rp <= rp_adv;
                    end
                    r_full <= (wp_adv == (r_full ? rp_adv : r_rp));
                end
                obrb_pkg::OP_GET: begin
                    if (!cnt_zero) begin
                        r_rp   <= rp_adv;
                        r_full <= 1'b0;
                    end
                end
                obrb_pkg::OP_PEEK: begin
                end
                obrb_pkg::OP_RESET: begin
                    r_wp   <= '0;
                    r_rp   <= '0;
                    r_full <= 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            case (r_op)
                obrb_pkg::OP_GET: begin
                    r_xok <= !cnt_zero;
                    r_xrd <= !cnt_zero;
                end
                obrb_pkg::OP_PEEK: begin
                    r_xok <= peek_ok;
                    r_xrd <= peek_ok;
                end
                default: begin
                    r_xok <= 1'b1;
                    r_xrd <= 1'b0;
                end
            endcase
        end
    end

    // pointers already hold the post-operation state here
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_ok      <= r_xok;
            r_dout    <= r_xrd ? r_mem_q : '0;
            r_count   <= cnt[obrb_pkg::CNT_W-1:0];
            r_full_o  <= (cnt == r_cap);
            r_empty_o <= cnt_zero;
        end
    end

    assign o_ok       = r_ok;
    assign o_data_out = r_dout;
    assign o_count    = r_count;
    assign o_is_full  = r_full_o;
    assign o_is_empty = r_empty_o;

endmodule

[sv/overwriting_byte_ring_buffer_top.sv]
// Top level: overwriting byte ring buffer, controller plus datapath.
//
// Byte FIFO on a ring of up to DEPTH entries whose capacity is set at run
// time through the capacity register (1..DEPTH; 0 acts as 1, values above
// DEPTH saturate at DEPTH). Each input transfer carries one operation:
// put stores a byte and, when the ring is full, drops the oldest byte;
// get pops the oldest byte (ok low when empty); peek reads the entry at
// peek_index past the oldest without removing it (ok low when peek_index
// is not below the count); reset empties the ring. Each input transfer
// yields exactly one result transfer with ok, data_out (zero unless a get
// or peek succeeded), and count, is_full and is_empty after the operation.
// Writing the capacity register also empties the ring; write it only
// while no operation is in flight. The store is not cleared, so reads
// only return bytes written since the last emptying.
// Operations run one at a time: accept, execute with a registered read
// of the store, result load (held while the previous result waits); the
// store access and the pointer update of one operation must finish
// before the next one starts. The result register lets the next input
// transfer be accepted while the previous result still waits.
module overwriting_byte_ring_buffer_top #(
    parameter int DEPTH = obrb_pkg::DEF_DEPTH
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [obrb_pkg::CAP_W-1:0]  i_cfg_data,
    obrb_in_if.sink                     i_in,
    obrb_out_if.source                  o_out
);

    obrb_pkg::t_cmd cmd;

    // sequencing and handshakes
    obrb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_cmd       (cmd)
    );

    // store, pointers and result register
    obrb_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_operation  (i_in.operation),
        .i_data_in    (i_in.data_in),
        .i_peek_index (i_in.peek_index),
        .o_ok         (o_out.ok),
        .o_data_out   (o_out.data_out),
        .o_count      (o_out.count),
        .o_is_full    (o_out.is_full),
        .o_is_empty   (o_out.is_empty)
    );

endmodule

[tb/overwriting_byte_ring_buffer_top_tb.sv]
// Testbench: overwriting byte ring buffer, self-checking against a ring predictor.
module overwriting_byte_ring_buffer_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RING_DEPTH    = obrb_pkg::DEF_DEPTH;
    localparam int STALL_LIMIT   = 5000;   // cycles with no transfer before giving up
    localparam int SETTLE_CYCLES = 6;      // settle time after the last result, with margin
    localparam int REPORT_MAX    = 10;

    // one operation as sent on the input channel
    typedef struct packed {
        obrb_pkg::t_op                   op;
        logic [obrb_pkg::DATA_W-1:0]     din;
        logic [obrb_pkg::IDX_W-1:0]      pidx;
    } t_ring_op;

    // one result as seen on the output channel
    typedef struct packed {
        logic                            ok;
        logic [obrb_pkg::DATA_W-1:0]     dout;
        logic [obrb_pkg::CNT_W-1:0]      count;
        logic                            full;
        logic                            empty;
    } t_ring_result;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n;
    logic                         i_cfg_we;
    logic [obrb_pkg::CAP_W-1:0]   i_cfg_data;

    obrb_in_if  op_ch ();
    obrb_out_if res_ch ();

    overwriting_byte_ring_buffer_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_in       (op_ch),
        .o_out      (res_ch)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Ring predictor: its own store, pointers, full flag and capacity reg.
    // Updated once per accepted input transfer, and on capacity writes.
    // ------------------------------------------------------------------
    logic [obrb_pkg::DATA_W-1:0] ring_mem [RING_DEPTH];
    int                          wr_ptr;
    int                          rd_ptr;
    bit                          ring_full;
    logic [obrb_pkg::CAP_W-1:0]  cap_reg;

    // capacity actually in force: zero acts as one, large values clamp to depth
    function automatic int ring_cap();
        int c;
        c = int'(cap_reg);
        if (c == 0) c = 1;
        if (c > RING_DEPTH) c = RING_DEPTH;
        return c;
    endfunction

    function automatic int ring_next(int p, int cap);
        return (p + 1 >= cap) ? 0 : p + 1;
    endfunction

    function automatic int ring_occupancy(int cap);
        if (ring_full) return cap;
        if (wr_ptr >= rd_ptr) return wr_ptr - rd_ptr;
        return cap - (rd_ptr - wr_ptr);
    endfunction

    function automatic t_ring_result ring_predict(t_ring_op it);
        t_ring_result r;
        int cap;
        int pos;
        int cnt;
        cap     = ring_cap();
        r.ok    = 1'b1;
        r.dout  = '0;
        if (wr_ptr >= cap) wr_ptr = 0;
        if (rd_ptr >= cap) rd_ptr = 0;
        case (it.op)
            obrb_pkg::OP_PUT: begin
                // full ring: newest byte lands on the oldest, read side moves on
                ring_mem[wr_ptr] = it.din;
                if (ring_full) rd_ptr = ring_next(rd_ptr, cap);
                wr_ptr    = ring_next(wr_ptr, cap);
                ring_full = (wr_ptr == rd_ptr);
            end
            obrb_pkg::OP_GET: begin
                if (ring_occupancy(cap) == 0) begin
                    r.ok = 1'b0;
                end else begin
                    r.dout    = ring_mem[rd_ptr];
                    ring_full = 1'b0;
                    rd_ptr    = ring_next(rd_ptr, cap);
                end
            end
            obrb_pkg::OP_PEEK: begin
                if (int'(it.pidx) >= ring_occupancy(cap)) begin
                    r.ok = 1'b0;
                end else begin
                    pos = rd_ptr + int'(it.pidx);
                    if (pos >= cap) pos -= cap;
                    r.dout = ring_mem[pos];
                end
            end
            default: begin
                wr_ptr    = 0;
                rd_ptr    = 0;
                ring_full = 1'b0;
            end
        endcase
        cnt     = ring_occupancy(cap);
        r.count = obrb_pkg::CNT_W'(cnt);
        r.full  = (cnt == cap);
        r.empty = (cnt == 0);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Queues, counters and gap shaping
    // ------------------------------------------------------------------
    t_ring_op     ops_to_send [$];
    t_ring_result pending_results [$];
    t_ring_op     cur_op;

    int ops_accepted    = 0;
    int results_checked = 0;
    int mismatches      = 0;
    int cfg_writes      = 0;
    int refused_ops     = 0;   // results with ok low
    int full_results    = 0;
    int stall_cycles    = 0;

    // stimulus-side view of fill level, so peeks can target live entries
    int gen_cap;
    int gen_count;

    int send_gap   = 0;
    int recv_stall = 0;
    bit send_burst = 1'b0;
    bit recv_burst = 1'b0;

    // mostly short gaps, now and then a long one
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(4, 24);
    endfunction

    // ------------------------------------------------------------------
    // Driver: presents queued operations, predicts at each input transfer
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            op_ch.valid <= 1'b0;
            send_gap = 0;
        end else begin
            if (op_ch.valid && op_ch.ready) begin
                pending_results.push_back(ring_predict(cur_op));
                ops_accepted++;
            end
            // slot is free when nothing is offered or the offer just went through
            if (!op_ch.valid || op_ch.ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    op_ch.valid <= 1'b0;
                end else if (ops_to_send.size() > 0) begin
                    cur_op = ops_to_send.pop_front();
                    op_ch.valid      <= 1'b1;
                    op_ch.operation  <= cur_op.op;
                    op_ch.data_in    <= cur_op.din;
                    op_ch.peek_index <= cur_op.pidx;
                    send_gap = send_burst ? 0 : idle_len();
                end else begin
                    op_ch.valid <= 1'b0;
                end
            end
            // stretches of back-to-back offers
            if ($urandom_range(0, 63) == 0) send_burst = !send_burst;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: random back-pressure, checks each result transfer in order
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : result_monitor
        t_ring_result want;
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
            recv_stall = 0;
        end else begin
            if (res_ch.valid && res_ch.ready) begin
                if (pending_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("%0t: result with nothing outstanding: ok=%0b data=%02h count=%0d",
                                 $realtime, res_ch.ok, res_ch.data_out, res_ch.count);
                end else begin
                    want = pending_results.pop_front();
                    results_checked++;
                    if (!want.ok) refused_ops++;
                    if (want.full) full_results++;
                    if (res_ch.ok !== want.ok || res_ch.data_out !== want.dout ||
                        res_ch.count !== want.count || res_ch.is_full !== want.full ||
                        res_ch.is_empty !== want.empty) begin
                        mismatches++;
                        if (mismatches <= REPORT_MAX) begin
                            $write("%0t: result %0d mismatch: expected ok=%0b data=%02h ",
                                   $realtime, results_checked, want.ok, want.dout);
                            $write("count=%0d full=%0b empty=%0b, ",
                                   want.count, want.full, want.empty);
                            $display("got ok=%0b data=%02h count=%0d full=%0b empty=%0b",
                                     res_ch.ok, res_ch.data_out, res_ch.count,
                                     res_ch.is_full, res_ch.is_empty);
                        end
                    end
                end
            end
            if (recv_stall > 0) begin
                recv_stall--;
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= 1'b1;
                if (!recv_burst && $urandom_range(0, 99) < 20) recv_stall = idle_len();
            end
            if ($urandom_range(0, 63) == 0) recv_burst = !recv_burst;
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: too long without any transfer means the block hung
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we || (op_ch.valid && op_ch.ready) ||
            (res_ch.valid && res_ch.ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("watchdog: %0d cycles without a transfer, %0d results outstanding",
                     stall_cycles, pending_results.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic queue_op(obrb_pkg::t_op op, int din, int pidx);
        t_ring_op it;
        it.op   = op;
        it.din  = obrb_pkg::DATA_W'(din);
        it.pidx = obrb_pkg::IDX_W'(pidx);
        ops_to_send.push_back(it);
        case (op)
            obrb_pkg::OP_PUT:  if (gen_count < gen_cap) gen_count++;
            obrb_pkg::OP_GET:  if (gen_count > 0) gen_count--;
            obrb_pkg::OP_PEEK: ;
            default:           gen_count = 0;
        endcase
    endtask

    // weights in percent; whatever is left over goes to the reset op
    task automatic queue_random(int put_w, int get_w, int peek_w);
        int            r;
        int            pidx;
        obrb_pkg::t_op op;
        r = $urandom_range(0, 99);
        if (r < put_w)                       op = obrb_pkg::OP_PUT;
        else if (r < put_w + get_w)          op = obrb_pkg::OP_GET;
        else if (r < put_w + get_w + peek_w) op = obrb_pkg::OP_PEEK;
        else                                 op = obrb_pkg::OP_RESET;
        // most peeks hit a live entry, the rest roam the full index range
        if (gen_count > 0 && $urandom_range(0, 3) != 0)
            pidx = $urandom_range(0, gen_count - 1);
        else
            pidx = $urandom_range(0, 255);
        queue_op(op, $urandom_range(0, 255), pidx);
    endtask

    // sample at the falling edge so the driver's and monitor's updates have landed
    task automatic wait_idle();
        do @(negedge i_clk);
        while (ops_to_send.size() != 0 || op_ch.valid || pending_results.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // only called while idle; the write also empties the ring
    task automatic set_capacity(logic [obrb_pkg::CAP_W-1:0] v);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        cap_reg   = v;
        wr_ptr    = 0;
        rd_ptr    = 0;
        ring_full = 1'b0;
        gen_cap   = ring_cap();
        gen_count = 0;
        cfg_writes++;
    endtask

    task automatic run_phase(logic [obrb_pkg::CAP_W-1:0] cap, int n, int put_w, int get_w,
                             int peek_w);
        set_capacity(cap);
        repeat (n) queue_random(put_w, get_w, peek_w);
        wait_idle();
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_data       = '0;
        op_ch.valid      = 1'b0;
        op_ch.operation  = obrb_pkg::OP_PUT;
        op_ch.data_in    = '0;
        op_ch.peek_index = '0;
        res_ch.ready     = 1'b0;
        cap_reg          = obrb_pkg::CAP_RESET;
        wr_ptr           = 0;
        rd_ptr           = 0;
        ring_full        = 1'b0;
        gen_cap          = ring_cap();
        gen_count        = 0;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed, capacity at its reset value: empty-ring refusals,
        // byte extremes, peeks in and out of range, and the reset op
        queue_op(obrb_pkg::OP_GET,   0,    0);
        queue_op(obrb_pkg::OP_PEEK,  0,    0);
        queue_op(obrb_pkg::OP_PEEK,  0,  255);
        queue_op(obrb_pkg::OP_PUT,   8'h00, 0);
        queue_op(obrb_pkg::OP_PUT,   8'hFF, 0);
        queue_op(obrb_pkg::OP_PUT,   8'hA5, 0);
        queue_op(obrb_pkg::OP_PEEK,  0,    0);
        queue_op(obrb_pkg::OP_PEEK,  0,    2);
        queue_op(obrb_pkg::OP_PEEK,  0,    3);
        queue_op(obrb_pkg::OP_PEEK,  0,  255);
        queue_op(obrb_pkg::OP_GET,   0,    0);
        queue_op(obrb_pkg::OP_GET,   0,    0);
        queue_op(obrb_pkg::OP_RESET, 8'hFF, 255);
        queue_op(obrb_pkg::OP_GET,   0,    0);
        queue_op(obrb_pkg::OP_PUT,   8'h5A, 0);
        queue_op(obrb_pkg::OP_GET,   0,    0);
        wait_idle();

        // directed, capacity two: put into a full ring drops the oldest byte
        set_capacity(9'd2);
        queue_op(obrb_pkg::OP_PUT,  8'h11, 0);
        queue_op(obrb_pkg::OP_PUT,  8'h22, 0);
        queue_op(obrb_pkg::OP_PUT,  8'h33, 0);
        queue_op(obrb_pkg::OP_PEEK, 0, 0);
        queue_op(obrb_pkg::OP_PEEK, 0, 1);
        queue_op(obrb_pkg::OP_PEEK, 0, 2);
        queue_op(obrb_pkg::OP_GET,  0, 0);
        queue_op(obrb_pkg::OP_GET,  0, 0);
        queue_op(obrb_pkg::OP_GET,  0, 0);
        wait_idle();

        // random phases over the capacity range; zero acts as one
        run_phase(9'd1, 40, 50, 25, 20);
        run_phase(9'd0, 30, 45, 25, 25);
        run_phase(9'd2, 40, 45, 25, 25);

        // above depth clamps to a full-size ring: fill it past capacity so
        // the write pointer wraps and the oldest bytes drop, then peek at the far end
        set_capacity(9'd511);
        repeat (RING_DEPTH + 2)
            queue_op(obrb_pkg::OP_PUT, $urandom_range(0, 255), $urandom_range(0, 255));
        queue_op(obrb_pkg::OP_PEEK, 0, 255);
        queue_op(obrb_pkg::OP_PEEK, 0, 0);
        queue_op(obrb_pkg::OP_PEEK, 0, 254);
        repeat (12) queue_random(30, 30, 35);
        wait_idle();

        run_phase(9'd257, 30, 45, 25, 25);
        repeat (3) run_phase(obrb_pkg::CAP_W'($urandom_range(3, 16)), 40, 45, 25, 25);
        run_phase(9'd256, 30, 45, 25, 25);

        $display("covered %0d operations under %0d capacity writes, %0d results checked",
                 ops_accepted, cfg_writes, results_checked);
        $display("%0d results refused (ok low), %0d with the ring full",
                 refused_ops, full_results);
        if (pending_results.size() != 0)
            $display("%0d results never arrived", pending_results.size());
        if (mismatches == 0 && pending_results.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
